/* hdl/whole_word_mask_filter_macros.svh */
// ---------------------------------------------------------------------------
// whole word mask filter assertion macros
// concurrent checks clocked on clk_i, off while rst_ni is low
// ---------------------------------------------------------------------------
`ifndef WHOLE_WORD_MASK_FILTER_MACROS_SVH
`define WHOLE_WORD_MASK_FILTER_MACROS_SVH

`ifndef ASSERT_OFF
`define WWMF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("wwmf assertion failed");
`define WWMF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wwmf assertion failed");
`else
`define WWMF_ASSERT(lbl, prop)
`define WWMF_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

/* hdl/wwmf_pkg.sv */
// ---------------------------------------------------------------------------
// wwmf_pkg
// shared constants for the whole word mask filter
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wwmf_pkg;

  localparam int unsigned MAX_WORD_LEN_DEF = 16;
  localparam int unsigned WORD_LEN_CAP     = 16;

  localparam logic [7:0] MASK_CHAR = 8'd88;
  localparam logic [7:0] CHAR_SP   = 8'd32;
  localparam logic [7:0] CHAR_TAB  = 8'd9;
  localparam logic [7:0] CHAR_CR   = 8'd13;
  localparam logic [7:0] CHAR_LF   = 8'd10;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_LEN  = 2'd2;

endpackage

`default_nettype wire

/* hdl/wwmf_ram.sv */
// ---------------------------------------------------------------------------
// wwmf_ram
// generic single write port ram with one registered read port
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wwmf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

/* hdl/whole_word_mask_filter.sv */
// ---------------------------------------------------------------------------
// whole_word_mask_filter
// Text stream filter: a token that equals the configured word leaves as a
// run of 'X' bytes, every other byte leaves unchanged and in order. Bytes
// of a token that still matches a prefix of the word sit in a small ram
// until the token ends or stops matching. A byte that releases held bytes
// is taken, then each held byte in turn is read from the ram and loaded
// into the output register, and last the byte itself when it follows the
// release; at most min(16, MAX_WORD_LEN) bytes are held. Held bytes leave
// one at a time through the single read port of the held byte ram, no new
// byte is taken until the release is over, and a full output register
// stalls the release. A new byte is taken while the last result still waits
// in the output register, as long as that register drains in the same cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "whole_word_mask_filter_macros.svh"

module whole_word_mask_filter #(
  parameter int unsigned MAX_WORD_LEN = wwmf_pkg::MAX_WORD_LEN_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [wwmf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [63:0]                    cfg_data_i,
  // input stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [7:0]                     s_axis_tdata,  // in_char
  input  wire logic                           s_axis_tlast,  // in_string_end
  // output stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic      [7:0]                     m_axis_tdata,  // out_char
  output logic                                m_axis_tuser,  // run_last
  output logic                                m_axis_tlast   // out_string_end
);

  import wwmf_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WORD_LEN + 1);
  localparam int unsigned WW = (CW > 5) ? CW : 5;
  localparam int unsigned AW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_SEND = 2'd2;
  localparam logic [1:0] S_TAIL = 2'd3;

  logic [63:0]   word_lo_q, word_hi_q;
  logic [4:0]    word_len_q;
  logic [1:0]    state_q, state_d;
  logic [CW-1:0] held_q, held_d;
  logic          pass_q, pass_d;
  logic [CW-1:0] rel_idx_q, rel_idx_d;
  logic [CW-1:0] rel_cnt_q, rel_cnt_d;
  logic          whole_q, whole_d;
  logic          tail_q, tail_d;
  logic [7:0]    tail_char_q, tail_char_d;
  logic          end_q, end_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_char_q, out_char_d;
  logic          out_run_last_q, out_run_last_d;
  logic          out_end_q, out_end_d;

  logic          accept, out_free, is_ws, is_match, rd_en, wr_en, rel_done;
  logic [4:0]    len5;
  logic [WW-1:0] len_w, len_sat, held_w;
  logic [127:0]  word_all;
  logic [7:0]    word_char, rd_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_lo_q  <= '0;
      word_hi_q  <= '0;
      word_len_q <= 5'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_WORD_LOW:  word_lo_q  <= cfg_data_i;
        REG_WORD_HIGH: word_hi_q  <= cfg_data_i;
        REG_WORD_LEN:  word_len_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign len5     = (word_len_q > 5'(WORD_LEN_CAP)) ? 5'(WORD_LEN_CAP) : word_len_q;
  assign len_w    = WW'(len5);
  assign len_sat  = (len_w > WW'(MAX_WORD_LEN)) ? WW'(MAX_WORD_LEN) : len_w;
  assign held_w   = WW'(held_q);
  assign word_all = {word_hi_q, word_lo_q};
  assign word_char = word_all[{held_w[3:0], 3'b000} +: 8];

  assign is_ws = (s_axis_tdata == CHAR_SP) || (s_axis_tdata == CHAR_TAB) ||
                 (s_axis_tdata == CHAR_CR) || (s_axis_tdata == CHAR_LF);
  assign is_match = !is_ws && !pass_q && (held_w < len_sat) && (s_axis_tdata == word_char);
  assign wr_en    = accept && is_match;
  assign rd_en    = (state_q == S_READ);
  assign rel_done = (rel_idx_q + CW'(1)) == rel_cnt_q;

  wwmf_ram #(
    .WIDTH(8),
    .DEPTH(MAX_WORD_LEN),
    .AW   (AW)
  ) u_held_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(held_q[AW-1:0]),
    .wr_data_i(s_axis_tdata),
    .rd_en_i  (rd_en),
    .rd_addr_i(rel_idx_q[AW-1:0]),
    .rd_data_o(rd_data)
  );

  always_comb begin
    state_d        = state_q;
    held_d         = held_q;
    pass_d         = pass_q;
    rel_idx_d      = rel_idx_q;
    rel_cnt_d      = rel_cnt_q;
    whole_d        = whole_q;
    tail_d         = tail_q;
    tail_char_d    = tail_char_q;
    end_d          = end_q;
    out_valid_d    = out_valid_q && !m_axis_tready;
    out_char_d     = out_char_q;
    out_run_last_d = out_run_last_q;
    out_end_d      = out_end_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          end_d       = s_axis_tlast;
          tail_char_d = s_axis_tdata;
          rel_idx_d   = '0;
          if (is_ws) begin
            whole_d = !pass_q && (len_sat != '0) && (held_w == len_sat);
            pass_d  = 1'b0;
            held_d  = '0;
            if (held_q != '0) begin
              rel_cnt_d = held_q;
              tail_d    = 1'b1;
              state_d   = S_READ;
            end else begin
              out_valid_d    = 1'b1;
              out_char_d     = s_axis_tdata;
              out_run_last_d = 1'b1;
              out_end_d      = s_axis_tlast;
            end
          end else if (pass_q) begin
            out_valid_d    = 1'b1;
            out_char_d     = s_axis_tdata;
            out_run_last_d = 1'b1;
            out_end_d      = s_axis_tlast;
          end else if (is_match) begin
            held_d = held_q + CW'(1);
            if (s_axis_tlast) begin
              rel_cnt_d = held_q + CW'(1);
              whole_d   = (held_w + WW'(1)) == len_sat;
              tail_d    = 1'b0;
              held_d    = '0;
              state_d   = S_READ;
            end
          end else begin
            whole_d = 1'b0;
            pass_d  = 1'b1;
            held_d  = '0;
            if (held_q != '0) begin
              rel_cnt_d = held_q;
              tail_d    = 1'b1;
              state_d   = S_READ;
            end else begin
              out_valid_d    = 1'b1;
              out_char_d     = s_axis_tdata;
              out_run_last_d = 1'b1;
              out_end_d      = s_axis_tlast;
            end
          end
          if (s_axis_tlast) begin
            pass_d = 1'b0;
            held_d = '0;
          end
        end
      end
      S_READ: begin
        state_d = S_SEND;
      end
      S_SEND: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_char_d     = whole_q ? MASK_CHAR : rd_data;
          out_run_last_d = rel_done && !tail_q;
          out_end_d      = rel_done && !tail_q && end_q;
          rel_idx_d      = rel_idx_q + CW'(1);
          if (!rel_done) begin
            state_d = S_READ;
          end else if (tail_q) begin
            state_d = S_TAIL;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_TAIL: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_char_d     = tail_char_q;
          out_run_last_d = 1'b1;
          out_end_d      = end_q;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held_q      <= '0;
      pass_q      <= 1'b0;
      rel_idx_q   <= '0;
      rel_cnt_q   <= '0;
      whole_q     <= 1'b0;
      tail_q      <= 1'b0;
      end_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      pass_q      <= pass_d;
      rel_idx_q   <= rel_idx_d;
      rel_cnt_q   <= rel_cnt_d;
      whole_q     <= whole_d;
      tail_q      <= tail_d;
      end_q       <= end_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tail_char_q    <= tail_char_d;
    out_char_q     <= out_char_d;
    out_run_last_q <= out_run_last_d;
    out_end_q      <= out_end_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tuser  = out_run_last_q;
  assign m_axis_tlast  = out_end_q;

  // held bytes and a failed token never coexist
  `WWMF_ASSERT_IMPL(a_pass_no_held, pass_q, held_q == '0)
  `WWMF_ASSERT(a_held_bound, CW'(MAX_WORD_LEN) >= held_q)
  `WWMF_ASSERT_IMPL(a_send_in_range, state_q == S_SEND, rel_idx_q < rel_cnt_q)
  `WWMF_ASSERT_IMPL(a_send_after_read, state_q == S_SEND && $past(state_q) != S_SEND,
                    $past(state_q) == S_READ)
  `WWMF_ASSERT_IMPL(a_string_end_clears, accept && s_axis_tlast,
                    ##1 (held_q == '0 && !pass_q))

endmodule

`default_nettype wire
